>>> rtl/swpc_pkg.sv
// ----------------------------------------------------------------------------
// swpc_pkg
// Shared constants and types of the sliding window peak count block.
// ----------------------------------------------------------------------------
package swpc_pkg;

	localparam int FIFO_DEPTH = 256;
	localparam int STAMP_W    = 32;
	localparam int WIN_W      = 31;
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int IDX_W      = $clog2(FIFO_DEPTH);
	localparam int DIFF_W     = (STAMP_W > WIN_W) ? STAMP_W : WIN_W;

	localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(60);

	typedef logic [STAMP_W-1:0] stamp_t;
	typedef logic [CNT_W-1:0]   count_t;
	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [WIN_W-1:0]   window_t;

	// Broadcast control for the row of stamp cells
	typedef struct packed {
		logic   shift;
		logic   wr;
		idx_t   widx;
		stamp_t wdata;
	} cell_ctl_t;

endpackage

>>> rtl/swpc_if.sv
// ----------------------------------------------------------------------------
// swpc_if
// Valid/ready channels of the sliding window peak count block.
// ----------------------------------------------------------------------------
interface swpc_evt_if;
	import swpc_pkg::*;
	logic   valid;
	logic   ready;
	stamp_t timestamp;
	logic   last;
	modport source (output valid, output timestamp, output last, input ready);
	modport sink   (input valid, input timestamp, input last, output ready);
endinterface

interface swpc_res_if;
	import swpc_pkg::*;
	logic   valid;
	logic   ready;
	stamp_t best_start;
	stamp_t best_end;
	count_t best_count;
	logic   overflowed;
	modport source (output valid, output best_start, output best_end,
		output best_count, output overflowed, input ready);
	modport sink   (input valid, input best_start, input best_end,
		input best_count, input overflowed, output ready);
endinterface

interface swpc_cfg_if;
	import swpc_pkg::*;
	logic    valid;
	logic    ready;
	window_t window_seconds;
	modport source (output valid, output window_seconds, input ready);
	modport sink   (input valid, input window_seconds, output ready);
endinterface

>>> rtl/swpc_cell.sv
// ----------------------------------------------------------------------------
// swpc_cell
// One stamp slot of the FIFO row: loads a new stamp or its neighbour's.
// ----------------------------------------------------------------------------
module swpc_cell (
	input  logic              clk,
	input  swpc_pkg::cell_ctl_t ctl,
	input  swpc_pkg::idx_t    idx,
	input  swpc_pkg::stamp_t  nbr,
	output swpc_pkg::stamp_t  stamp
);
	import swpc_pkg::*;

	stamp_t stamp_q;

	// Write takes priority: the tail slot is written while the row advances
	always_ff @(posedge clk) begin
		if (ctl.wr && (ctl.widx == idx)) begin
			stamp_q <= ctl.wdata;
		end else if (ctl.shift) begin
			stamp_q <= nbr;
		end
	end

	assign stamp = stamp_q;

endmodule

>>> rtl/swpc_chain.sv
// ----------------------------------------------------------------------------
// swpc_chain
// Row of stamp cells; slot 0 is the FIFO head, a pop advances the whole row.
// ----------------------------------------------------------------------------
module swpc_chain (
	input  logic                clk,
	input  swpc_pkg::cell_ctl_t ctl,
	output swpc_pkg::stamp_t    head0,
	output swpc_pkg::stamp_t    head1
);
	import swpc_pkg::*;

	stamp_t stamp_w [FIFO_DEPTH];

	for (genvar i = 0; i < FIFO_DEPTH; i++) begin : g_cell
		stamp_t nbr_w;
		if (i < FIFO_DEPTH - 1) begin : g_mid
			assign nbr_w = stamp_w[i+1];
		end else begin : g_end
			assign nbr_w = stamp_w[i];
		end
		swpc_cell u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.idx   (IDX_W'(i)),
			.nbr   (nbr_w),
			.stamp (stamp_w[i])
		);
	end

	assign head0 = stamp_w[0];
	assign head1 = stamp_w[1];

endmodule

>>> rtl/sliding_window_peak_count_core.sv
// ----------------------------------------------------------------------------
// sliding_window_peak_count_core
// Finds the busiest window of a stream of event stamps.
// ----------------------------------------------------------------------------
// Channels: evt carries one event word (timestamp, last); res carries one
// result word (best_start, best_end, best_count, overflowed) after each word
// marked last; cfg writes window_seconds and is always ready.
// Stamps sit in a row of cells whose head is slot 0. After an event word is
// taken the block pops stamps from the head one per cycle (one compare on
// the head stamp per cycle), then pushes the new stamp and updates the best
// record; the next event word is taken only after that push. Each stamp is
// popped at most once.
// The result word sits in an output register from the cycle after the push
// until taken; further events are accepted meanwhile, and only the push of a
// later last word waits for that register to drain.
// Reset clears the stream state and sets window_seconds to 60; the stream
// state clears again after each last word. Stamp cells are not reset.
// ----------------------------------------------------------------------------
module sliding_window_peak_count_core (
	input  logic       clk,
	input  logic       arst_n,
	swpc_evt_if.sink   evt,
	swpc_res_if.source res,
	swpc_cfg_if.sink   cfg
);
	import swpc_pkg::*;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_EVICT = 1'b1;

	logic      state_q;
	stamp_t    now_q;
	logic      last_q;
	count_t    occ_q;
	stamp_t    best_first_q;
	stamp_t    best_last_q;
	count_t    best_total_q;
	logic      ovf_q;
	window_t   window_q;
	logic      out_valid_q;
	stamp_t    out_start_q;
	stamp_t    out_end_q;
	count_t    out_count_q;
	logic      out_ovf_q;

	cell_ctl_t ctl;
	stamp_t    head0;
	stamp_t    head1;
	logic      evictable;
	logic      stall;
	logic      push_go;
	logic      full;
	count_t    new_occ;
	stamp_t    new_head;
	logic      better;
	stamp_t    nb_first;
	stamp_t    nb_last;
	count_t    nb_total;
	logic      nb_ovf;
	logic      out_take;

	swpc_chain u_chain (
		.clk   (clk),
		.ctl   (ctl),
		.head0 (head0),
		.head1 (head1)
	);

	assign evictable = (occ_q != '0) && (now_q > head0) &&
		(DIFF_W'(now_q - head0) > DIFF_W'(window_q));
	assign out_take  = out_valid_q && res.ready;
	// hold the final push while an earlier result is still waiting
	assign stall     = last_q && out_valid_q && !res.ready;
	assign push_go   = (state_q == ST_EVICT) && !evictable && !stall;
	assign full      = (occ_q == CNT_W'(FIFO_DEPTH));
	assign new_occ   = full ? occ_q : CNT_W'(occ_q + 1'b1);

	always_comb begin
		if (occ_q == '0) begin
			new_head = now_q;
		end else if (full) begin
			new_head = head1;
		end else begin
			new_head = head0;
		end
	end

	assign better   = (new_occ > best_total_q);
	assign nb_first = better ? new_head : best_first_q;
	assign nb_last  = better ? now_q : best_last_q;
	assign nb_total = better ? new_occ : best_total_q;
	assign nb_ovf   = ovf_q | full;

	always_comb begin
		ctl.shift = 1'b0;
		ctl.wr    = 1'b0;
		ctl.widx  = full ? IDX_W'(FIFO_DEPTH - 1) : occ_q[IDX_W-1:0];
		ctl.wdata = now_q;
		if (state_q == ST_EVICT) begin
			if (evictable) begin
				ctl.shift = 1'b1;
			end else if (push_go) begin
				ctl.shift = full;
				ctl.wr    = 1'b1;
			end
		end
	end

	assign evt.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			occ_q        <= '0;
			best_first_q <= '0;
			best_last_q  <= '0;
			best_total_q <= '0;
			ovf_q        <= 1'b0;
			window_q     <= WINDOW_RESET;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				window_q <= cfg.window_seconds;
			end
			if (push_go && last_q) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (evt.valid) begin
						state_q <= ST_EVICT;
					end
				end
				ST_EVICT: begin
					if (evictable) begin
						occ_q <= CNT_W'(occ_q - 1'b1);
					end else if (push_go) begin
						state_q <= ST_IDLE;
						if (last_q) begin
							occ_q        <= '0;
							best_first_q <= '0;
							best_last_q  <= '0;
							best_total_q <= '0;
							ovf_q        <= 1'b0;
						end else begin
							occ_q        <= new_occ;
							best_first_q <= nb_first;
							best_last_q  <= nb_last;
							best_total_q <= nb_total;
							ovf_q        <= nb_ovf;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			now_q  <= evt.timestamp;
			last_q <= evt.last;
		end
		if (push_go && last_q) begin
			out_start_q <= nb_first;
			out_end_q   <= nb_last;
			out_count_q <= nb_total;
			out_ovf_q   <= nb_ovf;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.best_start = out_start_q;
	assign res.best_end   = out_end_q;
	assign res.best_count = out_count_q;
	assign res.overflowed = out_ovf_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(FIFO_DEPTH))
		else $error("stamp count above FIFO depth");

	a_best_covers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (best_total_q >= occ_q))
		else $error("best count below current occupancy");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (best_total_q == CNT_W'(FIFO_DEPTH)))
		else $error("overflow flag without saturated best count");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(push_go && last_q) |=> ((occ_q == '0) && out_valid_q))
		else $error("stream state not cleared after last word");

endmodule
